// File: rtl/core/drt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dump request tracker.
// No dependencies; every other file refers to it by scoped names.
package drt_pkg;

  localparam int SLOT_W  = 8;
  localparam int OP_W    = 3;
  localparam int RETRY_W = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [SLOT_W-1:0]  SLOT_NONE   = 8'hff;
  localparam logic [RETRY_W-1:0] RETRY_RESET = 32'd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RETRY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_POLL        = 3'd0,
    OP_STATUS_SENT = 3'd1,
    OP_STATUS_RPLY = 3'd2,
    OP_DUMP_SENT   = 3'd3,
    OP_DUMP_RPLY   = 3'd4,
    OP_STATUS_TMO  = 3'd5,
    OP_DUMP_TMO    = 3'd6,
    OP_RESTART     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_DUMP   = 2'd1,
    PH_READY  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [RETRY_W-1:0] retry_interval;
    logic               refresh_same_slot;
  } cfg_t;

  typedef struct packed {
    logic   ok;
    logic   needs_dump;
    logic   selection_changed;
    logic   status_due;
    logic   can_poll;
    phase_t phase;
  } result_t;

endpackage

// File: rtl/core/drt_item_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces for the dump request tracker.
// Depends on drt_pkg for field widths.
interface drt_item_if #(
  parameter int TIME_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [drt_pkg::OP_W-1:0]    opcode;
  logic [TIME_BITS-1:0]        now;
  logic [drt_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, output opcode, output now, output slot, input ready);
  modport sink   (input valid, input opcode, input now, input slot, output ready);
endinterface

interface drt_result_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       needs_dump;
  logic       selection_changed;
  logic       status_due;
  logic       can_poll;
  logic [1:0] phase;

  modport source (output valid, output ok, output needs_dump, output selection_changed,
                  output status_due, output can_poll, output phase, input ready);
  modport sink   (input valid, input ok, input needs_dump, input selection_changed,
                  input status_due, input can_poll, input phase, output ready);
endinterface

// File: rtl/core/drt_in_reg.sv
`timescale 1ns / 1ps
// Input register stage: captures one request and holds it until the engine takes it.
// Depends on drt_pkg.
module drt_in_reg #(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [drt_pkg::OP_W-1:0]   in_opcode,
  input  logic [TIME_BITS-1:0]       in_now,
  input  logic [drt_pkg::SLOT_W-1:0] in_slot,
  input  logic                       advance,
  output logic                       valid,
  output drt_pkg::opcode_t           opcode,
  output logic [TIME_BITS-1:0]       now,
  output logic [drt_pkg::SLOT_W-1:0] slot
);

  // stage empties when the engine advances, so a new request can land the same edge
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      opcode <= drt_pkg::opcode_t'(in_opcode);
      now    <= in_now;
      slot   <= in_slot;
    end
  end

endmodule

// File: rtl/core/drt_engine.sv
`timescale 1ns / 1ps
// Tracker state and per-request update logic; produces the result for one request.
// Depends on drt_pkg.
module drt_engine #(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  drt_pkg::opcode_t           opcode,
  input  logic [TIME_BITS-1:0]       now,
  input  logic [drt_pkg::SLOT_W-1:0] slot,
  input  drt_pkg::cfg_t              cfg,
  output drt_pkg::result_t           result
);

  localparam int CMP_W = (TIME_BITS > drt_pkg::RETRY_W) ? TIME_BITS : drt_pkg::RETRY_W;

  drt_pkg::phase_t             phase_reg, phase_reg_next;
  logic [drt_pkg::SLOT_W-1:0]  current_slot, current_slot_next;
  logic                        status_pending, status_pending_next;
  logic                        dump_pending, dump_pending_next;
  logic [TIME_BITS-1:0]        status_sent_time, status_sent_time_next;
  logic [TIME_BITS-1:0]        dump_sent_time, dump_sent_time_next;

  logic [TIME_BITS-1:0] status_age, dump_age, status_age_next;
  logic [CMP_W-1:0]     retry_ext;
  logic                 status_elapsed, dump_elapsed, status_elapsed_next;
  logic                 ok, need, changed;

  // wrapping age of each outstanding request
  assign retry_ext      = CMP_W'(cfg.retry_interval);
  assign status_age     = now - status_sent_time;
  assign dump_age       = now - dump_sent_time;
  assign status_elapsed = CMP_W'(status_age) >= retry_ext;
  assign dump_elapsed   = CMP_W'(dump_age) >= retry_ext;

  always_comb begin
    phase_reg_next        = phase_reg;
    current_slot_next     = current_slot;
    status_pending_next   = status_pending;
    dump_pending_next     = dump_pending;
    status_sent_time_next = status_sent_time;
    dump_sent_time_next   = dump_sent_time;
    ok      = 1'b0;
    need    = 1'b0;
    changed = 1'b0;
    unique case (opcode)
      drt_pkg::OP_POLL: begin
      end
      drt_pkg::OP_STATUS_SENT: begin
        status_pending_next   = 1'b1;
        status_sent_time_next = now;
        ok = 1'b1;
      end
      drt_pkg::OP_STATUS_RPLY: begin
        if (status_pending) begin
          status_pending_next = 1'b0;
          ok      = 1'b1;
          changed = current_slot != slot;
          need    = (phase_reg == drt_pkg::PH_STATUS) || changed ||
                    (phase_reg == drt_pkg::PH_READY && cfg.refresh_same_slot);
          current_slot_next = slot;
          if (need) begin
            phase_reg_next    = drt_pkg::PH_DUMP;
            dump_pending_next = 1'b0;
          end
        end
      end
      drt_pkg::OP_DUMP_SENT: begin
        if (phase_reg == drt_pkg::PH_DUMP) begin
          dump_pending_next   = 1'b1;
          dump_sent_time_next = now;
          ok = 1'b1;
        end
      end
      drt_pkg::OP_DUMP_RPLY: begin
        if (phase_reg == drt_pkg::PH_DUMP && dump_pending && slot == current_slot) begin
          dump_pending_next = 1'b0;
          phase_reg_next    = drt_pkg::PH_READY;
          ok = 1'b1;
        end
      end
      drt_pkg::OP_STATUS_TMO: begin
        if (status_pending && status_elapsed) begin
          status_pending_next = 1'b0;
          ok = 1'b1;
        end
      end
      drt_pkg::OP_DUMP_TMO: begin
        if (phase_reg == drt_pkg::PH_DUMP && dump_pending && dump_elapsed) begin
          phase_reg_next      = drt_pkg::PH_STATUS;
          status_pending_next = 1'b0;
          dump_pending_next   = 1'b0;
          ok = 1'b1;
        end
      end
      drt_pkg::OP_RESTART: begin
        phase_reg_next        = drt_pkg::PH_STATUS;
        current_slot_next     = drt_pkg::SLOT_NONE;
        status_pending_next   = 1'b0;
        dump_pending_next     = 1'b0;
        status_sent_time_next = '0;
        dump_sent_time_next   = '0;
        ok = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // status_due looks at the state after this request
  assign status_age_next     = now - status_sent_time_next;
  assign status_elapsed_next = CMP_W'(status_age_next) >= retry_ext;

  always_comb begin
    result.ok                = ok;
    result.needs_dump        = need;
    result.selection_changed = changed;
    result.status_due        = (phase_reg_next == drt_pkg::PH_STATUS) &&
                               (!status_pending_next || status_elapsed_next);
    result.can_poll          = (phase_reg_next == drt_pkg::PH_READY) && !status_pending_next;
    result.phase             = phase_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= drt_pkg::PH_STATUS;
      current_slot     <= drt_pkg::SLOT_NONE;
      status_pending   <= 1'b0;
      dump_pending     <= 1'b0;
      status_sent_time <= '0;
      dump_sent_time   <= '0;
    end else if (fire) begin
      phase_reg        <= phase_reg_next;
      current_slot     <= current_slot_next;
      status_pending   <= status_pending_next;
      dump_pending     <= dump_pending_next;
      status_sent_time <= status_sent_time_next;
      dump_sent_time   <= dump_sent_time_next;
    end
  end

endmodule

// File: rtl/core/drt_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one finished result until the sink takes it.
// Depends on drt_pkg.
module drt_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  drt_pkg::result_t result_next,
  output logic             advance,
  output logic             valid,
  input  logic             ready,
  output drt_pkg::result_t result
);

  // a held result that is being taken this cycle frees the slot for the next one
  assign advance = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/core/dump_request_tracker_core.sv
`timescale 1ns / 1ps
// Top level of the dump request tracker: config registers, input stage, engine, result stage.
// Depends on drt_pkg, drt_item_if, drt_result_if, drt_in_reg, drt_engine, drt_out_reg.
//
//   port     dir   handshake      payload
//   item     in    valid/ready    opcode, now, slot
//   result   out   valid/ready    ok, needs_dump, selection_changed, status_due,
//                                 can_poll, phase
//   wr_*     in    wr_en          wr_index, wr_data (no read-back)
//
// One request per cycle sustained while the result sink is ready; a request is first
// captured in the input register, and its result loads into the result register once
// that register is free. Synchronous active-high reset clears the tracker state and
// loads the register defaults. A stalled result holds the result register; the input
// register then takes a new request only if it is empty.
module dump_request_tracker_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  drt_item_if.sink                      item,
  drt_result_if.source                  result,
  input  logic                          wr_en,
  input  logic [drt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [drt_pkg::CFG_W-1:0]     wr_data
);

  drt_pkg::cfg_t              cfg;
  logic                       s1_valid;
  drt_pkg::opcode_t           s1_opcode;
  logic [TIME_BITS-1:0]       s1_now;
  logic [drt_pkg::SLOT_W-1:0] s1_slot;
  logic                       advance;
  logic                       fire;
  drt_pkg::result_t           res_next;
  drt_pkg::result_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_interval    <= drt_pkg::RETRY_RESET;
      cfg.refresh_same_slot <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        drt_pkg::REG_RETRY:   cfg.retry_interval    <= wr_data[drt_pkg::RETRY_W-1:0];
        drt_pkg::REG_REFRESH: cfg.refresh_same_slot <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  drt_in_reg #(
    .TIME_BITS (TIME_BITS)
  ) u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_opcode (item.opcode),
    .in_now    (item.now),
    .in_slot   (item.slot),
    .advance   (advance),
    .valid     (s1_valid),
    .opcode    (s1_opcode),
    .now       (s1_now),
    .slot      (s1_slot)
  );

  assign fire = s1_valid && advance;

  drt_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .opcode (s1_opcode),
    .now    (s1_now),
    .slot   (s1_slot),
    .cfg    (cfg),
    .result (res_next)
  );

  drt_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_valid),
    .result_next (res_next),
    .advance     (advance),
    .valid       (result.valid),
    .ready       (result.ready),
    .result      (res)
  );

  assign result.ok                = res.ok;
  assign result.needs_dump        = res.needs_dump;
  assign result.selection_changed = res.selection_changed;
  assign result.status_due        = res.status_due;
  assign result.can_poll          = res.can_poll;
  assign result.phase             = res.phase;

endmodule
